// File: hdl/csvt_pkg.sv
`timescale 1ns / 1ps

package csvt_pkg;

  localparam int ROW_BITS    = 32;
  localparam int COLUMN_BITS = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SEPARATOR  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_QUOTE      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_QUOTES_ENA = 2'd2;

  localparam logic [7:0] SEPARATOR_RESET = 8'h3B;
  localparam logic [7:0] QUOTE_RESET     = 8'h22;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CHAR_LF         = 8'h0A;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_TAB        = 8'h09;

  typedef enum logic [2:0] {
    ST_BOL        = 3'd0,
    ST_AFTER_CR   = 3'd1,
    ST_BOF        = 3'd2,
    ST_PLAIN      = 3'd3,
    ST_QUOTED     = 3'd4,
    ST_QUOTE_SEEN = 3'd5,
    ST_TRAIL      = 3'd6,
    ST_BAD        = 3'd7
  } parse_state_t;

  typedef enum logic [2:0] {
    TK_ROW   = 3'd0,
    TK_BYTE  = 3'd1,
    TK_FEND  = 3'd2,
    TK_REND  = 3'd3,
    TK_FLUSH = 3'd4
  } token_kind_t;

  // everything one input byte produces: an optional row begin plus at most one main token
  typedef struct packed {
    logic                   has_row;
    logic                   has_main;
    token_kind_t            main_kind;
    logic [7:0]             main_byte;
    logic                   main_quoted;
    logic                   incomplete;
    logic [ROW_BITS-1:0]    row;
    logic [COLUMN_BITS-1:0] col;
  } bundle_t;

  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  content;
    logic        quoted;
    logic [31:0] row;
    logic [15:0] col;
    logic        incomplete;
    logic        last;
  } token_t;

endpackage

// File: hdl/csvt_front.sv
`timescale 1ns / 1ps

module csvt_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [csvt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [7:0]                            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_data_byte,
  input  logic                                  in_flush,
  input  logic                                  q_ready,
  output logic                                  q_push,
  output csvt_pkg::bundle_t                     q_data
);
  import csvt_pkg::*;

  logic [7:0]             sep_r;
  logic [7:0]             quote_r;
  logic                   quotes_ena_r;
  parse_state_t           st_r, st_nxt, s_eff;
  logic [ROW_BITS-1:0]    row_r, row_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt, col_base;
  logic                   row_inc, col_inc, skip;
  logic                   is_sep, is_q, is_cr, is_lf, is_ws;
  logic                   accept;
  bundle_t                bnd;

  assign is_sep = (in_data_byte == sep_r);
  assign is_q   = (in_data_byte == quote_r);
  assign is_cr  = (in_data_byte == CHAR_CR);
  assign is_lf  = (in_data_byte == CHAR_LF);
  assign is_ws  = (in_data_byte == CHAR_SPACE) || (in_data_byte == CHAR_TAB);

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (bnd.has_row || bnd.has_main);
  assign q_data   = bnd;

  always_comb begin
    bnd      = '0;
    skip     = 1'b0;
    col_base = col_r;
    row_inc  = 1'b0;
    col_inc  = 1'b0;
    s_eff    = st_r;
    st_nxt   = st_r;
    if (in_flush) begin
      bnd.has_main   = 1'b1;
      bnd.main_kind  = TK_FLUSH;
      bnd.incomplete = !((st_r == ST_BOL) || (st_r == ST_AFTER_CR));
    end else begin
      // prefix: a new record opens with a row begin and the byte is handled right after
      unique case (st_r)
        ST_BOL: begin
          bnd.has_row = 1'b1;
          col_base    = '0;
          s_eff       = ST_BOF;
        end
        ST_AFTER_CR: begin
          if (is_lf) begin
            st_nxt = ST_BOL;
            skip   = 1'b1;
          end else begin
            bnd.has_row = 1'b1;
            col_base    = '0;
            s_eff       = ST_BOF;
          end
        end
        default: ;
      endcase
      if (!skip && s_eff == ST_BOF) begin
        if (quotes_ena_r && is_q) begin
          st_nxt = ST_QUOTED;
          skip   = 1'b1;
        end else begin
          s_eff = ST_PLAIN;
        end
      end
      if (!skip && s_eff == ST_QUOTE_SEEN && !is_q) s_eff = ST_TRAIL;
      if (!skip) begin
        st_nxt = s_eff;
        unique case (s_eff)
          ST_PLAIN: begin
            bnd.has_main = 1'b1;
            if (is_sep) begin
              bnd.main_kind = TK_FEND;
              col_inc       = 1'b1;
              st_nxt        = ST_BOF;
            end else if (is_cr || is_lf) begin
              bnd.main_kind = TK_REND;
              row_inc       = 1'b1;
              st_nxt        = is_cr ? ST_AFTER_CR : ST_BOL;
            end else begin
              bnd.main_kind = TK_BYTE;
              bnd.main_byte = in_data_byte;
            end
          end
          ST_QUOTED: begin
            if (is_q) begin
              st_nxt = ST_QUOTE_SEEN;
            end else begin
              bnd.has_main    = 1'b1;
              bnd.main_kind   = TK_BYTE;
              bnd.main_byte   = in_data_byte;
              bnd.main_quoted = 1'b1;
            end
          end
          ST_QUOTE_SEEN: begin
            // doubled quote
            bnd.has_main    = 1'b1;
            bnd.main_kind   = TK_BYTE;
            bnd.main_byte   = quote_r;
            bnd.main_quoted = 1'b1;
            st_nxt          = ST_QUOTED;
          end
          ST_TRAIL: begin
            if (is_ws) begin
              st_nxt = ST_TRAIL;
            end else if (is_sep) begin
              bnd.has_main    = 1'b1;
              bnd.main_kind   = TK_FEND;
              bnd.main_quoted = 1'b1;
              col_inc         = 1'b1;
              st_nxt          = ST_BOF;
            end else if (is_cr || is_lf) begin
              bnd.has_main    = 1'b1;
              bnd.main_kind   = TK_REND;
              bnd.main_quoted = 1'b1;
              row_inc         = 1'b1;
              st_nxt          = is_cr ? ST_AFTER_CR : ST_BOL;
            end else begin
              st_nxt = ST_BAD;
            end
          end
          ST_BAD: begin
            if (is_sep) begin
              st_nxt = ST_BOF;
            end else if (is_lf) begin
              row_inc = 1'b1;
              st_nxt  = ST_BOL;
            end
          end
          default: st_nxt = s_eff;
        endcase
      end
    end
    bnd.row = row_r;
    bnd.col = col_base;
    row_nxt = row_r + ROW_BITS'(row_inc);
    col_nxt = col_base + COLUMN_BITS'(col_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r        <= SEPARATOR_RESET;
      quote_r      <= QUOTE_RESET;
      quotes_ena_r <= 1'b1;
      st_r         <= ST_BOL;
      row_r        <= '0;
      col_r        <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SEPARATOR:  sep_r        <= cfg_data;
          CFG_QUOTE:      quote_r      <= cfg_data;
          CFG_QUOTES_ENA: quotes_ena_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        st_r  <= st_nxt;
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

endmodule

// File: hdl/csvt_queue.sv
`timescale 1ns / 1ps

module csvt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  csvt_pkg::bundle_t push_data,
  output logic              ready,
  input  logic              pop,
  output logic              head_valid,
  output csvt_pkg::bundle_t head
);
  import csvt_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  bundle_t               mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]   count_r;
  logic                  do_pop;

  assign ready      = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop)      count_r <= count_r + 1'b1;
      else if (!push && do_pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

// File: hdl/csvt_back.sv
`timescale 1ns / 1ps

module csvt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  csvt_pkg::bundle_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output csvt_pkg::token_t  out_tok
);
  import csvt_pkg::*;

  logic   out_valid_r;
  logic   row_sent_r, row_sent_nxt;
  logic   load;
  token_t tok_r, tok_nxt;

  assign load      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_tok   = tok_r;

  always_comb begin
    pop           = 1'b0;
    row_sent_nxt  = row_sent_r;
    tok_nxt       = '0;
    tok_nxt.row   = 32'(head.row);
    tok_nxt.col   = 16'(head.col);
    if (head.has_row && !row_sent_r) begin
      tok_nxt.kind = TK_ROW;
      tok_nxt.last = !head.has_main;
      if (head.has_main) row_sent_nxt = 1'b1;
      else               pop          = load && head_valid;
    end else begin
      tok_nxt.kind       = head.main_kind;
      tok_nxt.content    = head.main_byte;
      tok_nxt.quoted     = head.main_quoted;
      tok_nxt.incomplete = head.incomplete;
      tok_nxt.last       = 1'b1;
      pop                = load && head_valid;
      row_sent_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      row_sent_r  <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) row_sent_r <= row_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) tok_r <= tok_nxt;
  end

endmodule

// File: hdl/csv_byte_tokenizer_core.sv
`timescale 1ns / 1ps
// Channel   Handshake              Beat carries
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data (register write)
// in        in_valid/in_ready      in_data_byte, in_flush
// out       out_valid/out_ready    token kind, content, quoted, row, column,
//                                  incomplete, last_of_run
//
// One byte per cycle in while the queue has room; out sends one token per cycle
// while out_ready is high, so a record-opening byte holds the back end for its
// row begin and its own token. Each beat is queued, then loaded into the output
// register; the two-entry queue lets the front take bytes while out stalls.
// Synchronous active-low reset restores the register defaults and line start.

module csv_byte_tokenizer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csvt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [7:0]                          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_flush,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_token_kind,
  output logic [7:0]                          out_content_byte,
  output logic                                out_was_quoted,
  output logic [31:0]                         out_row_number,
  output logic [15:0]                         out_column_number,
  output logic                                out_incomplete,
  output logic                                out_last_of_run
);
  import csvt_pkg::*;

  logic    q_ready, q_push, q_pop, q_head_valid;
  bundle_t q_data, q_head;
  token_t  tok;

  assign cfg_ready = 1'b1;

  csvt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_flush     (in_flush),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  csvt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  csvt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_tok    (tok)
  );

  assign out_token_kind    = tok.kind;
  assign out_content_byte  = tok.content;
  assign out_was_quoted    = tok.quoted;
  assign out_row_number    = tok.row;
  assign out_column_number = tok.col;
  assign out_incomplete    = tok.incomplete;
  assign out_last_of_run   = tok.last;

endmodule
